FILE: design/cfp_pkg.sv
// cfp_pkg: shared types, codes and tables of the command frame parser
// no dependencies; imported by every cfp_* module and the top level
package cfp_pkg;

	localparam int BYTE_W      = 8;
	localparam int POS_W       = 3;
	localparam int STORE_BYTES = 7;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [POS_W-1:0] LAST_POS = 3'd7;

	// byte 0 layout
	localparam int VALID_BIT = 5;
	localparam logic [1:0] SEL_SET  = 2'd0;
	localparam logic [1:0] SEL_MEAS = 2'd1;

	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [3:0] HEAT_IDX_MASK = 4'hF;

	// command codes
	localparam logic [1:0] CMD_NONE    = 2'd0;
	localparam logic [1:0] CMD_MEASURE = 2'd1;
	localparam logic [1:0] CMD_SET     = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_CRC_ERR   = 3'd1;
	localparam logic [2:0] ST_INVALID   = 3'd2;
	localparam logic [2:0] ST_RANGE     = 3'd3;
	localparam logic [2:0] ST_NOT_APPL  = 3'd4;

	// parameter numbers
	localparam logic [2:0] PAR_NONE   = 3'd0;
	localparam logic [2:0] PAR_HEATER = 3'd1;
	localparam logic [2:0] PAR_ANODE  = 3'd2;
	localparam logic [2:0] PAR_SCREEN = 3'd3;
	localparam logic [2:0] PAR_GRID   = 3'd4;
	localparam logic [2:0] PAR_TICKS  = 3'd5;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_HEAT_INDEX_LIMIT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_VOLT_SCALE       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ANODE_LIMIT      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_LIMIT     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_STEP        = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_GRID_LIMIT       = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_TICK_INDEX_LIMIT = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_TICK_SCALE       = 3'd7;

	typedef struct packed {
		logic [2:0]  heat_index_limit;
		logic [7:0]  volt_scale;
		logic [15:0] anode_limit;
		logic [15:0] screen_limit;
		logic [7:0]  grid_step;
		logic [7:0]  grid_limit;
		logic [7:0]  tick_index_limit;
		logic [7:0]  tick_scale;
	} cfg_t;

	typedef struct packed {
		logic                                crc_ok;
		logic [STORE_BYTES-1:0][BYTE_W-1:0] bytes;
	} frame_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  frame_tag;
		logic [2:0]  status;
		logic [2:0]  bad_param;
		logic [15:0] bad_value;
		logic [6:0]  heater_volts;
		logic [15:0] anode_volts;
		logic [15:0] screen_volts;
		logic [7:0]  grid_volts;
		logic [15:0] heat_ticks;
	} result_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

	// heater setpoints in 0.1 V
	function automatic logic [6:0] heater_lookup(input logic [2:0] idx);
		logic [6:0] v;
		unique case (idx)
			3'd0: v = 7'd0;
			3'd1: v = 7'd14;
			3'd2: v = 7'd20;
			3'd3: v = 7'd25;
			3'd4: v = 7'd40;
			3'd5: v = 7'd50;
			3'd6: v = 7'd63;
			3'd7: v = 7'd126;
		endcase
		return v;
	endfunction

endpackage

FILE: design/cfp_regs.sv
// cfp_regs: configuration register bank of the command frame parser
// depends on cfp_pkg
module cfp_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [cfp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output cfp_pkg::cfg_t                   cfg
);
	import cfp_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.heat_index_limit <= 3'd7;
			cfg_q.volt_scale       <= 8'd10;
			cfg_q.anode_limit      <= 16'd300;
			cfg_q.screen_limit     <= 16'd300;
			cfg_q.grid_step        <= 8'd5;
			cfg_q.grid_limit       <= 8'd240;
			cfg_q.tick_index_limit <= 8'd63;
			cfg_q.tick_scale       <= 8'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_HEAT_INDEX_LIMIT: cfg_q.heat_index_limit <= cfg_data[2:0];
				REG_VOLT_SCALE:       cfg_q.volt_scale       <= cfg_data[7:0];
				REG_ANODE_LIMIT:      cfg_q.anode_limit      <= cfg_data;
				REG_SCREEN_LIMIT:     cfg_q.screen_limit     <= cfg_data;
				REG_GRID_STEP:        cfg_q.grid_step        <= cfg_data[7:0];
				REG_GRID_LIMIT:       cfg_q.grid_limit       <= cfg_data[7:0];
				REG_TICK_INDEX_LIMIT: cfg_q.tick_index_limit <= cfg_data[7:0];
				REG_TICK_SCALE:       cfg_q.tick_scale       <= cfg_data[7:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: design/cfp_collect.sv
// cfp_collect: byte position, running crc and frame store; hands a full frame
// to the decode stage through the _s1 register. depends on cfp_pkg
module cfp_collect (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   rx_byte,
	input  logic         frame_start,
	input  logic         s1_take,
	output logic         s1_valid,
	output cfp_pkg::frame_t s1_frame
);
	import cfp_pkg::*;

	logic [POS_W-1:0]                   pos_q;
	logic [7:0]                         crc_q;
	logic [STORE_BYTES-1:0][BYTE_W-1:0] store_q;
	logic                               valid_s1;
	frame_t                             frame_s1;

	logic [POS_W-1:0] pos_eff;
	logic [7:0]       crc_eff;
	logic             last_byte;
	logic             accept;

	assign in_ready  = !valid_s1 || s1_take;
	assign accept    = in_valid && in_ready;
	// frame start restarts position and crc for this word
	assign pos_eff   = frame_start ? '0 : pos_q;
	assign crc_eff   = frame_start ? 8'h00 : crc_q;
	assign last_byte = (pos_eff == LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			crc_q    <= 8'h00;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (last_byte) begin
					pos_q <= '0;
					crc_q <= 8'h00;
				end else begin
					pos_q <= pos_eff + 1'b1;
					crc_q <= crc8_update(crc_eff, rx_byte);
				end
			end
			valid_s1 <= (accept && last_byte) || (valid_s1 && !s1_take);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !last_byte) begin
			store_q[pos_eff] <= rx_byte;
		end
		if (accept && last_byte) begin
			frame_s1.bytes  <= store_q;
			frame_s1.crc_ok <= (rx_byte == crc_eff);
		end
	end

	assign s1_valid = valid_s1;
	assign s1_frame = frame_s1;

endmodule

FILE: design/cfp_decode.sv
// cfp_decode: command decode, parameter scaling and range checks, result register
// depends on cfp_pkg
module cfp_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  cfp_pkg::cfg_t   cfg,
	input  logic            s1_valid,
	input  cfp_pkg::frame_t s1_frame,
	output logic            s1_take,
	output logic            out_valid,
	input  logic            out_ready,
	output cfp_pkg::result_t result
);
	import cfp_pkg::*;

	logic    out_valid_q;
	result_t result_q;
	result_t res;

	logic [7:0]  b0;
	logic [1:0]  sel;
	logic [3:0]  heater_sel;
	logic [15:0] ua;
	logic [15:0] ug2;
	logic [15:0] g1;
	logic [15:0] ticks;

	assign b0         = s1_frame.bytes[0];
	assign sel        = b0[7:6];
	assign heater_sel = s1_frame.bytes[2][3:0] & HEAT_IDX_MASK;
	assign ua         = 16'(s1_frame.bytes[3]) * 16'(cfg.volt_scale);
	assign ug2        = 16'(s1_frame.bytes[4]) * 16'(cfg.volt_scale);
	assign g1         = 16'(s1_frame.bytes[5]) * 16'(cfg.grid_step);
	assign ticks      = 16'(s1_frame.bytes[6]) * 16'(cfg.tick_scale);

	always_comb begin
		res           = '0;
		res.frame_tag = s1_frame.bytes[1];
		priority if (!s1_frame.crc_ok) begin
			res.status = ST_CRC_ERR;
		end else if (!b0[VALID_BIT]) begin
			res.status = ST_INVALID;
		end else if (sel == SEL_MEAS) begin
			res.command = CMD_MEASURE;
			res.status  = ST_NOT_APPL;
		end else if (sel != SEL_SET) begin
			res.status = ST_INVALID;
		end else begin
			res.command = CMD_SET;
			// first out-of-range parameter stops the chain, later fields stay zero
			if (heater_sel > {1'b0, cfg.heat_index_limit}) begin
				res.status    = ST_RANGE;
				res.bad_param = PAR_HEATER;
				res.bad_value = 16'(heater_sel);
			end else begin
				res.heater_volts = heater_lookup(heater_sel[2:0]);
				if (ua > cfg.anode_limit) begin
					res.status    = ST_RANGE;
					res.bad_param = PAR_ANODE;
					res.bad_value = ua;
				end else begin
					res.anode_volts = ua;
					if (ug2 > cfg.screen_limit) begin
						res.status    = ST_RANGE;
						res.bad_param = PAR_SCREEN;
						res.bad_value = ug2;
					end else begin
						res.screen_volts = ug2;
						if (g1 > {8'h00, cfg.grid_limit}) begin
							res.status    = ST_RANGE;
							res.bad_param = PAR_GRID;
							res.bad_value = 16'(s1_frame.bytes[5]);
						end else begin
							res.grid_volts = g1[7:0];
							if (s1_frame.bytes[6] > cfg.tick_index_limit) begin
								res.status    = ST_RANGE;
								res.bad_param = PAR_TICKS;
								res.bad_value = 16'(s1_frame.bytes[6]);
							end else begin
								res.heat_ticks = ticks;
								res.status     = ST_OK;
							end
						end
					end
				end
			end
		end
	end

	assign s1_take = s1_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			result_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = result_q;

endmodule

FILE: design/command_frame_parser.sv
// command_frame_parser: top level of the command frame parser
// depends on cfp_pkg, cfp_regs, cfp_collect, cfp_decode
//
// Input channel (in_valid/in_ready) moves one frame byte per word, with
// frame_start marking byte 0. Eight bytes make a frame: bytes 0..6 feed a
// crc-8 (poly 0x07, init 0) and byte 7 is the expected crc. Only byte 7
// produces a result word on the output channel (out_valid/out_ready).
// Throughput: one byte per cycle while in_ready is high; crc and position
// update is a single registered step per byte.
// Path: byte 7 lands in the frame register at its accepting edge, and the
// decode loads the result register from it when that register is empty or
// being taken; out_valid rises with that load.
// Stall: the result register and the frame register each hold one frame, so
// bytes keep flowing until both are full; then in_ready drops until the
// receiver takes the waiting result.
// Reset: position and crc clear, pipeline empties, configuration registers
// return to defaults. The user must write configuration through cfg_write,
// cfg_index and cfg_data only while the block is idle; it is not enforced.
module command_frame_parser (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [cfp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [7:0]                      rx_byte,
	input  logic                            frame_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [1:0]                      command,
	output logic [7:0]                      frame_tag,
	output logic [2:0]                      status,
	output logic [2:0]                      bad_param,
	output logic [15:0]                     bad_value,
	output logic [6:0]                      heater_volts,
	output logic [15:0]                     anode_volts,
	output logic [15:0]                     screen_volts,
	output logic [7:0]                      grid_volts,
	output logic [15:0]                     heat_ticks
);
	import cfp_pkg::*;

	cfg_t    cfg;
	frame_t  s1_frame;
	logic    s1_valid;
	logic    s1_take;
	result_t result;

	cfp_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cfp_collect u_collect (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.rx_byte     (rx_byte),
		.frame_start (frame_start),
		.s1_take     (s1_take),
		.s1_valid    (s1_valid),
		.s1_frame    (s1_frame)
	);

	cfp_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.s1_valid  (s1_valid),
		.s1_frame  (s1_frame),
		.s1_take   (s1_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign command      = result.command;
	assign frame_tag    = result.frame_tag;
	assign status       = result.status;
	assign bad_param    = result.bad_param;
	assign bad_value    = result.bad_value;
	assign heater_volts = result.heater_volts;
	assign anode_volts  = result.anode_volts;
	assign screen_volts = result.screen_volts;
	assign grid_volts   = result.grid_volts;
	assign heat_ticks   = result.heat_ticks;

endmodule

FILE: tb/frame_result_checker.sv
// frame_result_checker: watches the byte and result channels of command_frame_parser,
// keeps its own copy of the frame state and settings, and compares each result word
// depends on cfp_pkg for the result layout, register indexes and code constants
module frame_result_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [cfp_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cfp_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [7:0]                      rx_byte,
	input  logic                            frame_start,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  cfp_pkg::result_t                observed,
	output int                              mismatches,
	output int                              pending,
	output int                              words_checked,
	output int                              set_ok_words,
	output int                              range_words
);
	import cfp_pkg::*;

	localparam logic [2:0] LAST_SLOT = 3'd7;
	localparam logic [7:0] FRAME_POLY = 8'h07;
	localparam cfg_t LIMITS_AT_RESET =
		{3'd7, 8'd10, 16'd300, 16'd300, 8'd5, 8'd240, 8'd63, 8'd1};
	// heater setpoints in 0.1 V, entry i at [i]
	localparam logic [7:0][6:0] HEATER_TENTHS =
		{7'd126, 7'd63, 7'd50, 7'd40, 7'd25, 7'd20, 7'd14, 7'd0};

	logic [2:0] slot;
	logic [7:0] frame_crc;
	logic [7:0] held [0:6];
	cfg_t       limits;
	result_t    expected_words [$];

	function automatic logic [7:0] crc_step(input logic [7:0] acc, input logic [7:0] b);
		logic [7:0] r;
		r = acc ^ b;
		repeat (8) r = r[7] ? ({r[6:0], 1'b0} ^ FRAME_POLY) : {r[6:0], 1'b0};
		return r;
	endfunction

	// decode of a complete frame, checks in the order the block applies them
	function automatic result_t decode_word(input logic [7:0] crc_byte);
		result_t    r;
		logic [3:0] heater_sel;
		logic [15:0] anode, screen, grid, ticks;
		r = '0;
		r.frame_tag = held[1];
		if (crc_byte != frame_crc) begin
			r.status = ST_CRC_ERR;
			return r;
		end
		if (!held[0][5]) begin
			r.status = ST_INVALID;
			return r;
		end
		if (held[0][7:6] == SEL_MEAS) begin
			r.command = CMD_MEASURE;
			r.status = ST_NOT_APPL;
			return r;
		end
		if (held[0][7:6] != SEL_SET) begin
			r.status = ST_INVALID;
			return r;
		end
		r.command = CMD_SET;
		r.status = ST_RANGE;
		heater_sel = held[2][3:0];
		if (heater_sel > {1'b0, limits.heat_index_limit}) begin
			r.bad_param = PAR_HEATER;
			r.bad_value = {12'd0, heater_sel};
			return r;
		end
		r.heater_volts = HEATER_TENTHS[heater_sel[2:0]];
		anode = held[3] * limits.volt_scale;
		if (anode > limits.anode_limit) begin
			r.bad_param = PAR_ANODE;
			r.bad_value = anode;
			return r;
		end
		r.anode_volts = anode;
		screen = held[4] * limits.volt_scale;
		if (screen > limits.screen_limit) begin
			r.bad_param = PAR_SCREEN;
			r.bad_value = screen;
			return r;
		end
		r.screen_volts = screen;
		grid = held[5] * limits.grid_step;
		if (grid > {8'd0, limits.grid_limit}) begin
			// grid1 reports the raw byte, not the scaled value
			r.bad_param = PAR_GRID;
			r.bad_value = {8'd0, held[5]};
			return r;
		end
		r.grid_volts = grid[7:0];
		if (held[6] > limits.tick_index_limit) begin
			r.bad_param = PAR_TICKS;
			r.bad_value = {8'd0, held[6]};
			return r;
		end
		ticks = held[6] * limits.tick_scale;
		r.heat_ticks = ticks;
		r.status = ST_OK;
		return r;
	endfunction

	function automatic string word_text(input result_t w);
		return $sformatf({"cmd=%0d tag=%02h status=%0d param=%0d value=%0d heater=%0d",
			" anode=%0d screen=%0d grid=%0d ticks=%0d"},
			w.command, w.frame_tag, w.status, w.bad_param, w.bad_value, w.heater_volts,
			w.anode_volts, w.screen_volts, w.grid_volts, w.heat_ticks);
	endfunction

	task automatic compare_word(input result_t want, input result_t got);
		string wrong;
		wrong = "";
		if (got.command !== want.command) wrong = {wrong, " command"};
		if (got.frame_tag !== want.frame_tag) wrong = {wrong, " frame_tag"};
		if (got.status !== want.status) wrong = {wrong, " status"};
		if (got.bad_param !== want.bad_param) wrong = {wrong, " bad_param"};
		if (got.bad_value !== want.bad_value) wrong = {wrong, " bad_value"};
		if (got.heater_volts !== want.heater_volts) wrong = {wrong, " heater_volts"};
		if (got.anode_volts !== want.anode_volts) wrong = {wrong, " anode_volts"};
		if (got.screen_volts !== want.screen_volts) wrong = {wrong, " screen_volts"};
		if (got.grid_volts !== want.grid_volts) wrong = {wrong, " grid_volts"};
		if (got.heat_ticks !== want.heat_ticks) wrong = {wrong, " heat_ticks"};
		if (wrong != "") begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("result word %0d differs in%s", words_checked, wrong);
				$display("  expected %s", word_text(want));
				$display("  actual   %s", word_text(got));
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot = '0;
			frame_crc = '0;
			limits = LIMITS_AT_RESET;
			expected_words.delete();
			mismatches = 0;
			pending = 0;
			words_checked = 0;
			set_ok_words = 0;
			range_words = 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_HEAT_INDEX_LIMIT: limits.heat_index_limit = cfg_data[2:0];
					REG_VOLT_SCALE:       limits.volt_scale = cfg_data[7:0];
					REG_ANODE_LIMIT:      limits.anode_limit = cfg_data;
					REG_SCREEN_LIMIT:     limits.screen_limit = cfg_data;
					REG_GRID_STEP:        limits.grid_step = cfg_data[7:0];
					REG_GRID_LIMIT:       limits.grid_limit = cfg_data[7:0];
					REG_TICK_INDEX_LIMIT: limits.tick_index_limit = cfg_data[7:0];
					REG_TICK_SCALE:       limits.tick_scale = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				words_checked++;
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result word with nothing expected: %s", word_text(observed));
				end else begin
					compare_word(expected_words.pop_front(), observed);
				end
			end
			if (in_valid && in_ready) begin
				if (frame_start) begin
					slot = '0;
					frame_crc = '0;
				end
				if (slot != LAST_SLOT) begin
					held[slot] = rx_byte;
					frame_crc = crc_step(frame_crc, rx_byte);
					slot = slot + 3'd1;
				end else begin
					// byte 7 closes the frame and carries the crc
					expected_words.push_back(decode_word(rx_byte));
					if (expected_words[$].status == ST_OK) set_ok_words++;
					if (expected_words[$].status == ST_RANGE) range_words++;
					slot = '0;
					frame_crc = '0;
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

FILE: tb/tb_command_frame_parser.sv
// tb_command_frame_parser: stimulus and verdict for command_frame_parser, with
// directed frames, biased random frames and several register settings
// depends on cfp_pkg, command_frame_parser and frame_result_checker
module tb_command_frame_parser;
	import cfp_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 7;
	localparam int BYTES_PER_PHASE = 136;
	localparam cfg_t LIMITS_AT_RESET =
		{3'd7, 8'd10, 16'd300, 16'd300, 8'd5, 8'd240, 8'd63, 8'd1};
	localparam cfg_t LIMITS_HIGH =
		{3'd7, 8'd255, 16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255};
	localparam cfg_t LIMITS_LOW =
		{3'd0, 8'd1, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0};

	typedef enum logic [1:0] {RX_ALWAYS, RX_PATTERN, RX_SPARSE, RX_COIN} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_write;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  rx_byte;
	logic        frame_start;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  command;
	logic [7:0]  frame_tag;
	logic [2:0]  status;
	logic [2:0]  bad_param;
	logic [15:0] bad_value;
	logic [6:0]  heater_volts;
	logic [15:0] anode_volts;
	logic [15:0] screen_volts;
	logic [7:0]  grid_volts;
	logic [15:0] heat_ticks;

	int mismatches, pending, words_checked, set_ok_words, range_words;

	cfg_t        active = LIMITS_AT_RESET;
	int          bytes_sent = 0;
	int          burst_left = 0;
	bit          sender_idles = 1'b0;
	bit          aligned = 1'b1;
	int unsigned cycle_count = 0;
	rx_mode_t    rx_mode = RX_ALWAYS;
	int          rx_hold = 0;
	logic [15:0] rx_pattern = 16'hFFFF;

	command_frame_parser dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .frame_start(frame_start),
		.out_valid(out_valid), .out_ready(out_ready),
		.command(command), .frame_tag(frame_tag), .status(status), .bad_param(bad_param),
		.bad_value(bad_value), .heater_volts(heater_volts), .anode_volts(anode_volts),
		.screen_volts(screen_volts), .grid_volts(grid_volts), .heat_ticks(heat_ticks)
	);

	frame_result_checker watcher (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte), .frame_start(frame_start),
		.out_valid(out_valid), .out_ready(out_ready),
		.observed({command, frame_tag, status, bad_param, bad_value, heater_volts,
			anode_volts, screen_volts, grid_volts, heat_ticks}),
		.mismatches(mismatches), .pending(pending), .words_checked(words_checked),
		.set_ok_words(set_ok_words), .range_words(range_words)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("command_frame_parser verification failed");
			$finish;
		end
	end

	// receiver stalls: modes last a random stretch, one of them never stalls
	always @(negedge clk) begin
		if (rx_hold == 0) begin
			rx_hold = $urandom_range(40, 300);
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_pattern = 16'($urandom()) | 16'h0001;
		end
		rx_hold--;
		rx_pattern = {rx_pattern[14:0], rx_pattern[15]};
		case (rx_mode)
			RX_ALWAYS:  out_ready <= 1'b1;
			RX_PATTERN: out_ready <= rx_pattern[0];
			RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
			default:    out_ready <= ($urandom_range(0, 1) == 0);
		endcase
	end

	// returns at the edge that took the word; valid stays up for the next call
	task automatic send_byte(input logic [7:0] b, input logic st);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			if (sender_idles) gap = $urandom_range(1, 6);
		end
		burst_left--;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		frame_start <= st;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic ship_frame(input logic [6:0][7:0] body, input bit corrupt, input bit restart);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 7; i++) begin
			acc ^= body[i];
			repeat (8) acc = acc[7] ? ({acc[6:0], 1'b0} ^ 8'h07) : {acc[6:0], 1'b0};
		end
		if (corrupt) acc ^= 8'h01 << $urandom_range(0, 7);
		for (int i = 0; i < 7; i++) send_byte(body[i], i == 0 && restart);
		send_byte(acc, 1'b0);
		aligned = 1'b1;
	endtask

	// parameter byte near the largest passing value, or past it when over is set
	function automatic logic [7:0] pick_param(input int cap, input bit over);
		if (cap >= 255) return 8'($urandom_range(0, 255));
		if (over) return 8'($urandom_range(0, 1) ? cap + 1 : $urandom_range(cap + 1, 255));
		return 8'($urandom_range(0, 1) ? cap : $urandom_range(0, cap));
	endfunction

	task automatic send_random_frame();
		logic [6:0][7:0] body;
		logic [3:0] heater_sel;
		int roll, heat_cap, anode_cap, screen_cap, grid_cap;
		roll = $urandom_range(0, 99);
		body = 56'({$urandom(), $urandom()});
		if (roll >= 80) begin
			// loose bytes with stray frame starts
			repeat ($urandom_range(1, 9)) send_byte(8'($urandom()), $urandom_range(0, 3) == 0);
			aligned = 1'b0;
		end else begin
			if (roll < 50) begin
				heat_cap = active.heat_index_limit;
				anode_cap = active.anode_limit / active.volt_scale;
				screen_cap = active.screen_limit / active.volt_scale;
				grid_cap = (active.grid_step == 0) ? 255 : active.grid_limit / active.grid_step;
				heater_sel = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(heat_cap + 1, 15)
					: $urandom_range(0, heat_cap));
				body[0] = {SEL_SET, 1'b1, body[0][4:0]};
				body[2] = {body[2][7:4], heater_sel};
				body[3] = pick_param(anode_cap, $urandom_range(0, 7) == 0);
				body[4] = pick_param(screen_cap, $urandom_range(0, 7) == 0);
				body[5] = pick_param(grid_cap, $urandom_range(0, 7) == 0);
				body[6] = pick_param(active.tick_index_limit, $urandom_range(0, 7) == 0);
			end else if (roll < 60) begin
				body[0] = {SEL_MEAS, 1'b1, body[0][4:0]};
			end else if (roll < 70) begin
				// either the valid bit clear or a reserved selector
				body[0] = $urandom_range(0, 1) ? {body[0][7:6], 1'b0, body[0][4:0]}
					: {1'b1, body[0][6], 1'b1, body[0][4:0]};
			end
			ship_frame(body, roll >= 70, !aligned || $urandom_range(0, 3) != 0);
		end
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [15:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
	endtask

	// narrow registers get junk above their width, which must be dropped
	task automatic load_settings(input cfg_t c);
		logic [15:0] junk;
		junk = 16'($urandom());
		put_reg(REG_HEAT_INDEX_LIMIT, {junk[15:3], c.heat_index_limit});
		put_reg(REG_VOLT_SCALE, {junk[7:0], c.volt_scale});
		put_reg(REG_ANODE_LIMIT, c.anode_limit);
		put_reg(REG_SCREEN_LIMIT, c.screen_limit);
		junk = 16'($urandom());
		put_reg(REG_GRID_STEP, {junk[15:8], c.grid_step});
		put_reg(REG_GRID_LIMIT, {junk[7:0], c.grid_limit});
		junk = 16'($urandom());
		put_reg(REG_TICK_INDEX_LIMIT, {junk[15:8], c.tick_index_limit});
		put_reg(REG_TICK_SCALE, {junk[7:0], c.tick_scale});
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic cfg_t random_settings();
		cfg_t c;
		c.heat_index_limit = 3'($urandom_range(0, 7));
		c.volt_scale = 8'($urandom_range(1, 255));
		c.anode_limit = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
			: $urandom_range(0, 3000));
		c.screen_limit = 16'($urandom_range(0, 1) ? $urandom_range(0, 65535)
			: $urandom_range(0, 3000));
		c.grid_step = 8'($urandom_range(0, 1) ? $urandom_range(0, 12) : $urandom_range(0, 255));
		c.grid_limit = 8'($urandom_range(0, 255));
		c.tick_index_limit = 8'($urandom_range(0, 255));
		c.tick_scale = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// stop sending, let every expected word come out, then the pipeline latency
	task automatic settle_block();
		int waited;
		waited = 0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0 && waited < 2000) begin
			@(negedge clk);
			waited++;
		end
		repeat (4) @(negedge clk);
	endtask

	initial begin
		logic [6:0][7:0] body;
		int phase_mark;
		cfg_write = 1'b0;
		cfg_index = REG_HEAT_INDEX_LIMIT;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		frame_start = 1'b0;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// partial frame dropped by a restart
		send_byte(8'h20, 1'b1);
		send_byte(8'hFF, 1'b0);
		// set accepted with every parameter at its limit under reset settings
		body[0] = 8'h3F;
		body[1] = 8'hFF;
		body[2] = 8'hF7;
		body[3] = 8'd30;
		body[4] = 8'd30;
		body[5] = 8'd48;
		body[6] = 8'd63;
		ship_frame(body, 1'b0, 1'b1);
		// measure frame right after, relying on the wrap without frame_start
		body = '0;
		body[0] = 8'h60;
		ship_frame(body, 1'b0, 1'b0);
		// reserved selector hidden behind a bad crc
		body[0] = 8'hE0;
		body[1] = 8'h5A;
		ship_frame(body, 1'b1, 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				active = (p == 1) ? LIMITS_HIGH : (p == 2) ? LIMITS_LOW : random_settings();
				load_settings(active);
			end
			sender_idles = ($urandom_range(0, 3) != 0);
			burst_left = 0;
			phase_mark = bytes_sent;
			while (bytes_sent - phase_mark < BYTES_PER_PHASE) send_random_frame();
			settle_block();
		end

		$display("%0d bytes sent under %0d register settings, %0d result words compared",
			bytes_sent, PHASES, words_checked);
		$display("%0d set frames accepted, %0d out of range, %0d other outcomes",
			set_ok_words, range_words, words_checked - set_ok_words - range_words);
		if (mismatches == 0 && pending == 0) begin
			$display("command_frame_parser verification clean");
		end else begin
			$display("command_frame_parser verification failed");
		end
		$finish;
	end

endmodule
